// File: rtl/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

    // Longest PROXY header, counted from the P through CR LF.
    localparam logic [6:0] MAX_PROXY_LEN = 7'd108;

    // Length of the "PROXY " prefix and the header count once it has matched.
    localparam logic [2:0] PREFIX_LEN   = 3'd6;
    localparam logic [2:0] PREFIX_LAST  = 3'd5;
    localparam logic [2:0] PREFIX_SPLIT = 3'd4;
    localparam logic [6:0] HDR_START    = 7'd6;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Frame length read from the first two prefix bytes "PR" after a failed match.
    localparam logic [7:0]  REPLAY_HIGH = 8'h50;
    localparam logic [15:0] REPLAY_LEN  = 16'h5052;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_MATCH,
        PH_HEADER,
        PH_GOT_CR,
        PH_DEFRAME
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_HEADER,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_out;
        logic       msg_last;
        logic       run_last;
    } result_t;

    // The text "PROXY ".
    function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h52;
            3'd2:    b = 8'h4F;
            3'd3:    b = 8'h58;
            3'd4:    b = 8'h59;
            3'd5:    b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lpd_ifs.sv
`default_nettype none

interface lpd_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_in;
    logic        chunk_start;
    logic [15:0] chunk_len;

    modport source (output valid, output byte_in, output chunk_start, output chunk_len,
                    input ready);
    modport sink   (input valid, input byte_in, input chunk_start, input chunk_len,
                    output ready);
endinterface

interface lpd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_out;
    logic       msg_last;
    logic       run_last;

    modport source (output valid, output kind, output data_out, output msg_last,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input data_out, input msg_last,
                    input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/length_prefix_deframer_proxy_unit.sv
`default_nettype none

// Length-prefixed stream deframer with an optional PROXY v1 text header.
// The stream channel takes one received byte per item, with chunk_start and
// chunk_len marking the first byte of each received chunk. The result channel
// gives payload bytes (msg_last on the last byte of a frame), empty-frame
// markers, PROXY header bytes (msg_last on the closing LF) and a single error
// item, after which the block drops every further byte. run_last marks the
// last result caused by one input byte.
// An accepted byte is held in the input register and is then decoded in
// one pass into a four-entry result buffer, from which its results are
// offered in order. While the receiver takes every result, a byte that gives
// at most one result keeps the rate at one byte per cycle; a byte that gives
// several results (four at most, when the prefix completes or a long partial
// prefix is replayed into the deframer) holds the buffer until all are taken.
// Reset clears the decode state to await the first byte and empties both the
// input register and the result buffer. When the receiver stalls, the result
// buffer holds its items, the input register keeps one more byte, and then
// stream ready drops until the buffer drains.
module length_prefix_deframer_proxy_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpd_byte_if.sink    stream,
    lpd_result_if.source result
);
    import lpd_pkg::*;

    // Input register.
    logic        item_valid_reg, item_valid_next;
    logic [7:0]  item_byte_reg;
    logic        item_start_reg;
    logic [15:0] item_len_reg;

    // Decode state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  match_reg, match_next;
    logic [6:0]  proxy_reg, proxy_next;
    logic [7:0]  high_reg, high_next;
    logic        have_reg, have_next;
    logic [15:0] remain_reg, remain_next;
    logic        stopped_reg, stopped_next;

    // Result buffer: filled all at once, drained one item per cycle while the receiver is ready.
    result_t     slot_reg [4];
    result_t     slot_next [4];
    logic [2:0]  count_reg, count_next;
    logic [1:0]  ptr_reg, ptr_next;

    logic        stream_fire;
    logic        result_fire;
    logic        buf_free;
    logic        process;
    logic        active;
    logic        prefix_hit;
    logic        header_full;
    logic [7:0]  b;

    // One deframer step on the current byte.
    logic        df_emit;
    kind_t       df_kind;
    logic        df_last;
    logic [15:0] df_remain;
    logic        df_have;
    logic [7:0]  df_high;

    result_t     res [4];
    logic [2:0]  res_n;

    assign result_fire = result.valid && result.ready;
    assign stream_fire = stream.valid && stream.ready;

    // The buffer can take a new set of results when it is empty now or its
    // last item leaves in this cycle.
    assign buf_free     = (count_reg == 3'd0) || ((count_reg == 3'd1) && result.ready);
    assign process      = item_valid_reg && buf_free;
    assign active       = process && !stopped_reg;
    assign stream.ready = !item_valid_reg || process;

    assign b           = item_byte_reg;
    assign prefix_hit  = (b == prefix_byte(match_reg));
    assign header_full = (proxy_reg >= MAX_PROXY_LEN);

    assign result.valid    = (count_reg != 3'd0);
    assign result.kind     = slot_reg[ptr_reg].kind;
    assign result.data_out = slot_reg[ptr_reg].data_out;
    assign result.msg_last = slot_reg[ptr_reg].msg_last;
    assign result.run_last = slot_reg[ptr_reg].run_last;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (stream_fire)
        begin
            item_valid_next = 1'b1;
        end
        else if (process)
        begin
            item_valid_next = 1'b0;
        end
    end

    // Length reader and payload counter.
    always_comb
    begin
        df_emit   = 1'b0;
        df_kind   = KIND_PAYLOAD;
        df_last   = 1'b0;
        df_remain = remain_reg;
        df_have   = have_reg;
        df_high   = high_reg;
        if (remain_reg != 16'd0)
        begin
            df_remain = remain_reg - 16'd1;
            df_emit   = 1'b1;
            df_last   = (remain_reg == 16'd1);
        end
        else if (!have_reg)
        begin
            df_high = b;
            df_have = 1'b1;
        end
        else
        begin
            df_have = 1'b0;
            if ({high_reg, b} == 16'd0)
            begin
                df_emit = 1'b1;
                df_kind = KIND_EMPTY;
                df_last = 1'b1;
            end
            else
            begin
                df_remain = {high_reg, b};
            end
        end
    end

    // Next decode state.
    always_comb
    begin
        phase_next   = phase_reg;
        match_next   = match_reg;
        proxy_next   = proxy_reg;
        high_next    = high_reg;
        have_next    = have_reg;
        remain_next  = remain_reg;
        stopped_next = stopped_reg;
        if (active)
        begin
            unique case (phase_reg)
                PH_AWAIT:
                begin
                    if (item_start_reg && (item_len_reg >= 16'(PREFIX_LEN))
                        && (b == prefix_byte(3'd0)))
                    begin
                        match_next = 3'd1;
                        phase_next = PH_MATCH;
                    end
                    else
                    begin
                        phase_next  = PH_DEFRAME;
                        high_next   = df_high;
                        have_next   = df_have;
                        remain_next = df_remain;
                    end
                end
                PH_MATCH:
                begin
                    if (prefix_hit && (match_reg == PREFIX_LAST))
                    begin
                        match_next = PREFIX_SPLIT;
                        proxy_next = HDR_START;
                        phase_next = PH_HEADER;
                    end
                    else if (prefix_hit)
                    begin
                        match_next = match_reg + 3'd1;
                    end
                    else
                    begin
                        // Replay the matched prefix: the P and the byte after it form the length,
                        // everything after them is payload.
                        high_next = REPLAY_HIGH;
                        have_next = 1'b0;
                        if (match_reg == 3'd1)
                        begin
                            remain_next = {REPLAY_HIGH, b};
                        end
                        else
                        begin
                            remain_next = REPLAY_LEN - {13'd0, match_reg - 3'd1};
                        end
                        match_next = 3'd0;
                        phase_next = PH_DEFRAME;
                    end
                end
                PH_HEADER:
                begin
                    if (match_reg != PREFIX_LEN)
                    begin
                        match_next = PREFIX_LEN;
                    end
                    if (header_full)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        proxy_next = proxy_reg + 7'd1;
                        if (b == CHAR_CR)
                        begin
                            phase_next = PH_GOT_CR;
                        end
                    end
                end
                PH_GOT_CR:
                begin
                    if ((b != CHAR_LF) || header_full)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        proxy_next = proxy_reg + 7'd1;
                        phase_next = PH_DEFRAME;
                    end
                end
                PH_DEFRAME:
                begin
                    high_next   = df_high;
                    have_next   = df_have;
                    remain_next = df_remain;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Results of the current byte.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            res[j] = '{kind: KIND_PAYLOAD, data_out: 8'd0, msg_last: 1'b0, run_last: 1'b0};
        end
        res_n = 3'd0;
        if (active)
        begin
            unique case (phase_reg) inside
                PH_AWAIT, PH_DEFRAME:
                begin
                    // In the await phase a prefix start leaves the deframer idle
                    // with nothing to emit, so only the deframer step matters.
                    if (df_emit && !((phase_reg == PH_AWAIT) && item_start_reg
                        && (item_len_reg >= 16'(PREFIX_LEN)) && (b == prefix_byte(3'd0))))
                    begin
                        res[0].kind     = df_kind;
                        res[0].data_out = (df_kind == KIND_PAYLOAD) ? b : 8'd0;
                        res[0].msg_last = df_last;
                        res_n           = 3'd1;
                    end
                end
                PH_MATCH:
                begin
                    if (prefix_hit && (match_reg == PREFIX_LAST))
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            res[j].kind     = KIND_HEADER;
                            res[j].data_out = prefix_byte(3'(j));
                        end
                        res_n = 3'd4;
                    end
                    else if (!prefix_hit)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            res[j].kind     = KIND_PAYLOAD;
                            res[j].data_out = ((3'(j) + 3'd2) < match_reg)
                                              ? prefix_byte(3'(j) + 3'd2) : b;
                        end
                        res_n = match_reg - 3'd1;
                    end
                end
                PH_HEADER:
                begin
                    if (match_reg != PREFIX_LEN)
                    begin
                        res[0].kind     = KIND_HEADER;
                        res[0].data_out = prefix_byte(PREFIX_SPLIT);
                        res[1].kind     = KIND_HEADER;
                        res[1].data_out = prefix_byte(PREFIX_LAST);
                        res[2].kind     = header_full ? KIND_ERROR : KIND_HEADER;
                        res[2].data_out = header_full ? 8'd0 : b;
                        res_n           = 3'd3;
                    end
                    else
                    begin
                        res[0].kind     = header_full ? KIND_ERROR : KIND_HEADER;
                        res[0].data_out = header_full ? 8'd0 : b;
                        res_n           = 3'd1;
                    end
                end
                PH_GOT_CR:
                begin
                    if ((b != CHAR_LF) || header_full)
                    begin
                        res[0].kind = KIND_ERROR;
                    end
                    else
                    begin
                        res[0].kind     = KIND_HEADER;
                        res[0].data_out = CHAR_LF;
                        res[0].msg_last = 1'b1;
                    end
                    res_n = 3'd1;
                end
                default:
                begin
                    res_n = 3'd0;
                end
            endcase
        end
    end

    // Result buffer control.
    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        for (int j = 0; j < 4; j++)
        begin
            slot_next[j] = slot_reg[j];
        end
        if (process)
        begin
            for (int j = 0; j < 4; j++)
            begin
                slot_next[j]          = res[j];
                slot_next[j].run_last = ((3'(j) + 3'd1) == res_n);
            end
            count_next = res_n;
            ptr_next   = 2'd0;
        end
        else if (result_fire)
        begin
            count_next = count_reg - 3'd1;
            ptr_next   = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_AWAIT;
            match_reg      <= 3'd0;
            proxy_reg      <= 7'd0;
            high_reg       <= 8'd0;
            have_reg       <= 1'b0;
            remain_reg     <= 16'd0;
            stopped_reg    <= 1'b0;
            count_reg      <= 3'd0;
            ptr_reg        <= 2'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            match_reg      <= match_next;
            proxy_reg      <= proxy_next;
            high_reg       <= high_next;
            have_reg       <= have_next;
            remain_reg     <= remain_next;
            stopped_reg    <= stopped_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream_fire)
        begin
            item_byte_reg  <= stream.byte_in;
            item_start_reg <= stream.chunk_start;
            item_len_reg   <= stream.chunk_len;
        end
        for (int j = 0; j < 4; j++)
        begin
            slot_reg[j] <= slot_next[j];
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    // The six bytes of the "PROXY " signature.
    localparam logic [7:0] PROXY_TEXT [0:5] = '{8'h50, 8'h52, 8'h4F, 8'h58, 8'h59, 8'h20};

    // Longest header body that still fits: the signature and CR LF take eight bytes.
    localparam int MAX_BODY     = int'(MAX_PROXY_LEN) - 8;
    localparam int ITEMS        = 220;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int SHOWN_ERRORS = 10;

    // How the connection opens. Only one opening fits in a run because reset
    // is applied once and the header test is made on the first byte only.
    typedef enum {
        OPEN_PROXY,
        OPEN_REPLAY,
        OPEN_LONG_HDR,
        OPEN_BAD_CR
    } opening_t;

    // Ways for the signature test to fail.
    typedef enum {
        RP_NO_START,
        RP_SHORT_CHUNK,
        RP_NOT_P,
        RP_PARTIAL
    } replay_t;

    // Tracks the decoder state byte by byte and keeps the results that the
    // block owes, oldest first.
    class deframer_scoreboard;
        phase_t      phase;
        logic [2:0]  match_cnt;
        logic [6:0]  hdr_cnt;
        logic [7:0]  len_high;
        logic        have_high;
        logic [15:0] remaining;
        logic        stopped;
        int          step_results;
        int          mismatches;
        result_t     pending_results[$];

        function new();
            phase      = PH_AWAIT;
            match_cnt  = '0;
            hdr_cnt    = '0;
            len_high   = '0;
            have_high  = 1'b0;
            remaining  = '0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void add_result(kind_t k, logic [7:0] d, logic last);
            result_t r;
            if (step_results >= 4)
                return;
            r.kind     = k;
            r.data_out = d;
            r.msg_last = last;
            r.run_last = 1'b0;
            pending_results.push_back(r);
            step_results++;
        endfunction

        function void halt_on_error();
            add_result(KIND_ERROR, 8'h00, 1'b0);
            stopped = 1'b1;
        endfunction

        function void feed_deframer(logic [7:0] b);
            if (remaining != 16'd0)
            begin
                remaining = remaining - 16'd1;
                add_result(KIND_PAYLOAD, b, remaining == 16'd0);
            end
            else if (!have_high)
            begin
                len_high  = b;
                have_high = 1'b1;
            end
            else
            begin
                have_high = 1'b0;
                if ({len_high, b} == 16'd0)
                    add_result(KIND_EMPTY, 8'h00, 1'b1);
                else
                    remaining = {len_high, b};
            end
        endfunction

        function void feed_header(logic [7:0] b);
            if (phase == PH_HEADER)
            begin
                // The last two signature bytes go out ahead of the first body byte.
                while (match_cnt < PREFIX_LEN)
                begin
                    add_result(KIND_HEADER, PROXY_TEXT[match_cnt], 1'b0);
                    match_cnt++;
                end
                if (hdr_cnt >= MAX_PROXY_LEN)
                begin
                    halt_on_error();
                    return;
                end
                hdr_cnt++;
                add_result(KIND_HEADER, b, 1'b0);
                if (b == CHAR_CR)
                    phase = PH_GOT_CR;
            end
            else
            begin
                if (b != CHAR_LF || hdr_cnt >= MAX_PROXY_LEN)
                begin
                    halt_on_error();
                    return;
                end
                hdr_cnt++;
                add_result(KIND_HEADER, b, 1'b1);
                phase = PH_DEFRAME;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic st, logic [15:0] len);
            result_t r;
            step_results = 0;
            if (stopped)
                return;
            case (phase) inside
                PH_AWAIT:
                begin
                    if (st && len >= 16'd6 && b == PROXY_TEXT[0])
                    begin
                        match_cnt = 3'd1;
                        phase     = PH_MATCH;
                    end
                    else
                    begin
                        phase = PH_DEFRAME;
                        feed_deframer(b);
                    end
                end
                PH_MATCH:
                begin
                    if (match_cnt < PREFIX_LEN && b == PROXY_TEXT[match_cnt])
                    begin
                        match_cnt++;
                        if (match_cnt == PREFIX_LEN)
                        begin
                            for (int i = 0; i < 4; i++)
                                add_result(KIND_HEADER, PROXY_TEXT[i], 1'b0);
                            match_cnt = PREFIX_SPLIT;
                            hdr_cnt   = HDR_START;
                            phase     = PH_HEADER;
                        end
                    end
                    else
                    begin
                        // The matched part of the signature is framing data after all.
                        for (int i = 0; i < int'(match_cnt); i++)
                            feed_deframer(PROXY_TEXT[i]);
                        feed_deframer(b);
                        match_cnt = '0;
                        phase     = PH_DEFRAME;
                    end
                end
                PH_HEADER, PH_GOT_CR: feed_header(b);
                default: feed_deframer(b);
            endcase
            if (step_results > 0)
            begin
                r = pending_results.pop_back();
                r.run_last = 1'b1;
                pending_results.push_back(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: kind %0d data %02h msg_last %b run_last %b",
                             got.kind, got.data_out, got.msg_last, got.run_last);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.data_out !== want.data_out ||
                got.msg_last !== want.msg_last || got.run_last !== want.run_last)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display({"result mismatch: expected kind %0d data %02h msg_last %b ",
                              "run_last %b, got kind %0d data %02h msg_last %b run_last %b"},
                             want.kind, want.data_out, want.msg_last, want.run_last,
                             got.kind, got.data_out, got.msg_last, got.run_last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lpd_byte_if   byte_ch ();
    lpd_result_if result_ch ();

    length_prefix_deframer_proxy_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (result_ch)
    );

    deframer_scoreboard sb = new();

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;
    // Set for the closing part of the run, where neither side idles.
    bit calm = 1'b0;
    int n_items = 0;

    always #4 clk = ~clk;

    // Both channels are sampled at the rising edge. Stimulus changes only at
    // the falling edge, and the block updates its outputs after the edge, so
    // the values seen here are the ones the handshake used.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                sb.take_byte(byte_ch.byte_in, byte_ch.chunk_start, byte_ch.chunk_len);
            if (result_ch.valid && result_ch.ready)
                sb.check_result('{kind_t'(result_ch.kind), result_ch.data_out,
                                  result_ch.msg_last, result_ch.run_last});
        end
    end

    // Receiver. Outside the calm part it drops ready in random bursts. When
    // asked, it holds off for a long stretch so that the result buffer and
    // the input register fill up and the block has to stall the stream.
    initial
    begin : receiver
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Offers one byte and returns at the falling edge after it was accepted.
    // Outside the calm part a random gap may come first. The last stretch of
    // the run is calm.
    task automatic put_byte(input logic [7:0] b, input logic st, input logic [15:0] len);
        if (n_items >= ITEMS - 40)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.byte_in     <= b;
        byte_ch.chunk_start <= st;
        byte_ch.chunk_len   <= len;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        n_items++;
        @(negedge clk);
    endtask

    // A byte after the first one. The chunk marks are random since the block
    // no longer reads them.
    task automatic put_plain(input logic [7:0] b);
        put_byte(b, $urandom_range(0, 3) == 0, 16'($urandom));
    endtask

    // A chunk length that allows the signature test.
    function automatic logic [15:0] long_chunk();
        case ($urandom_range(0, 2))
            0:       return 16'd6;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(6, 65535));
        endcase
    endfunction

    // A header body byte; a CR would end the body.
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CHAR_CR);
        return c;
    endfunction

    task automatic send_signature();
        put_byte(PROXY_TEXT[0], 1'b1, long_chunk());
        for (int i = 1; i < 6; i++)
            put_plain(PROXY_TEXT[i]);
    endtask

    // One frame; its body is cut short once the run has sent its items.
    task automatic put_frame(input logic [15:0] len);
        put_plain(len[15:8]);
        put_plain(len[7:0]);
        for (int i = 0; i < int'(len) && n_items < ITEMS; i++)
            put_plain(8'($urandom));
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        opening_t   opening;
        replay_t    variant;
        int         k;
        int         body;
        int         r;
        logic [7:0] b;
        logic [15:0] len;

        byte_ch.valid       = 1'b0;
        byte_ch.byte_in     = 8'h00;
        byte_ch.chunk_start = 1'b0;
        byte_ch.chunk_len   = 16'h0000;
        rst_n               = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pick how this connection opens. A clean PROXY header is the most
        // common case; the two error cases stop the block for good, so they
        // get a run of their own now and then.
        r = $urandom_range(0, 19);
        if (r < 10)
            opening = OPEN_PROXY;
        else if (r < 16)
            opening = OPEN_REPLAY;
        else if (r < 18)
            opening = OPEN_LONG_HDR;
        else
            opening = OPEN_BAD_CR;

        case (opening)
            OPEN_PROXY:
            begin
                // A header with an empty body, the longest legal body, or
                // something in between; then an empty, a one-byte and a two-byte frame.
                r = $urandom_range(0, 3);
                body = (r == 0) ? 0 : (r == 1) ? MAX_BODY : $urandom_range(1, 40);
                send_signature();
                repeat (body) put_plain(body_char());
                put_plain(CHAR_CR);
                put_plain(CHAR_LF);
                put_plain(8'h00);
                put_plain(8'h00);
                put_plain(8'h00);
                put_plain(8'h01);
                put_plain(8'hFF);
                put_plain(8'h00);
                put_plain(8'h02);
                put_plain(8'h00);
                put_plain(8'hFF);
            end
            OPEN_REPLAY:
            begin
                variant = replay_t'($urandom_range(0, 3));
                case (variant)
                    // A byte that does not open a chunk cannot start the test, even a P.
                    RP_NO_START:
                        put_byte($urandom_range(0, 1) ? PROXY_TEXT[0] : 8'h00, 1'b0,
                                 16'($urandom));
                    // The first chunk is too short to hold the signature.
                    RP_SHORT_CHUNK:
                        put_byte(PROXY_TEXT[0], 1'b1, 16'($urandom_range(0, 5)));
                    RP_NOT_P:
                        put_byte(8'($urandom_range(0, 1)), 1'b1, long_chunk());
                    default:
                    begin
                        // Part of the signature matches, then a wrong byte
                        // sends the matched part into the deframer.
                        k = $urandom_range(1, 5);
                        put_byte(PROXY_TEXT[0], 1'b1, long_chunk());
                        for (int i = 1; i < k; i++)
                            put_plain(PROXY_TEXT[i]);
                        do
                            b = 8'($urandom);
                        while (b == PROXY_TEXT[k]);
                        put_plain(b);
                    end
                endcase
            end
            default: send_signature();
        endcase

        // Let everything owed so far come out before going on.
        byte_ch.valid <= 1'b0;
        wait_drained();
        hold_req = 1'b1;

        if (opening == OPEN_PROXY || opening == OPEN_REPLAY)
        begin
            // Go on with whatever frame the opening left open. After a
            // replayed P this is a frame of some twenty thousand bytes, so it
            // is only followed until the run has sent its items.
            if (sb.have_high)
                put_plain(sb.len_high == 8'h00 ? 8'($urandom_range(0, 20)) : 8'($urandom));
            while (sb.remaining != 16'd0 && n_items < ITEMS)
                put_plain(8'($urandom));
            // Well-formed frames with random bodies, mostly short.
            while (n_items < ITEMS)
            begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    len = 16'($urandom_range(0, 8));
                else if (r < 19)
                    len = 16'($urandom_range(9, 40));
                else
                    len = 16'($urandom_range(256, 300));
                put_frame(len);
            end
        end
        else
        begin
            if (opening == OPEN_LONG_HDR)
            begin
                if ($urandom_range(0, 1))
                begin
                    // The body fills the header to its limit; the next byte no longer fits.
                    repeat (MAX_BODY + 2) put_plain(body_char());
                end
                else
                begin
                    // The CR still fits, the LF would not.
                    repeat (MAX_BODY + 1) put_plain(body_char());
                    put_plain(CHAR_CR);
                    put_plain(CHAR_LF);
                end
            end
            else
            begin
                body = $urandom_range(0, 90);
                repeat (body) put_plain(body_char());
                put_plain(CHAR_CR);
                do
                    b = $urandom_range(0, 1) ? CHAR_CR : 8'($urandom);
                while (b == CHAR_LF);
                put_plain(b);
            end
            // The block has stopped; these bytes must give nothing.
            while (n_items < ITEMS)
                put_plain(8'($urandom));
        end

        calm = 1'b1;
        byte_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.pending_results.size() != 0)
            $display("%0d expected results never arrived", sb.pending_results.size());
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/lpd_pkg.sv
rtl/lpd_ifs.sv
rtl/length_prefix_deframer_proxy_unit.sv
tb/tb.sv
